// ----- rtl/puqe_pkg.sv -----
// Package for the particle update and quad expand pipeline: widths, coefficients, helpers.
package puqe_pkg;

  // Sine pipeline delay (input angle to registered sine).
  localparam int SIN_LAT = 7;
  // Total latency from input transfer to result strobe.
  localparam int PIPE_LAT = 13;

  // Horner coefficients, Q30, highest order first.
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C1 = 31'd1686629713;

  typedef logic signed [17:0] sine_t;

  // Round a signed product to nearest by 16 bits, ties away from zero.
  function automatic logic signed [34:0] rnd16(input logic signed [50:0] v);
    logic [51:0] mag;
    logic [51:0] sum;
    logic [34:0] res;
    mag = v[50] ? (52'd0 - {v[50], v}) : {1'b0, v};
    sum = mag + 52'd32768;
    res = sum[50:16];
    return v[50] ? -$signed(res) : $signed(res);
  endfunction

  // Saturate a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- rtl/particle_update_quad_expand_core.sv -----
// Top level: particle Euler step and rotated quad corner pipeline.
// One particle record is taken per clock (busy stays low) and its result
// appears on the out_ ports, marked by out_valid for one cycle. A record
// passes the seven-stage sine pipeline followed by the speed, time step,
// position and corner stages. The receiver cannot stall; results stream
// out in input order. time_step is written through cfg_we/cfg_wdata and
// is sampled in the time step stage.
module particle_update_quad_expand_core import puqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        in_slot,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_spin_angle,
  input  logic signed [31:0] in_speed,
  input  logic [30:0]        in_radius,
  input  logic               in_batch_end,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic [11:0]        out_slot,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_c0_x,
  output logic signed [31:0] out_c0_y,
  output logic signed [31:0] out_c1_x,
  output logic signed [31:0] out_c1_y,
  output logic signed [31:0] out_c2_x,
  output logic signed [31:0] out_c2_y,
  output logic signed [31:0] out_c3_x,
  output logic signed [31:0] out_c3_y,
  output logic               out_last
);

  assign busy = 1'b0;

  // Time step register
  logic [15:0] dt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= '0;
    end else if (cfg_we) begin
      dt_r <= cfg_wdata;
    end
  end

  // Valid bits
  logic [PIPE_LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], start & ~busy};
    end
  end

  // Four sine units
  sine_t sin_h, cos_h, sin_s, cos_s;
  logic [15:0] head_c, spin_c;
  assign head_c = in_heading + 16'd16384;
  assign spin_c = in_spin_angle + 16'd16384;
  puqe_sine u_sin_h (.clk(clk), .angle(in_heading),    .sine(sin_h));
  puqe_sine u_cos_h (.clk(clk), .angle(head_c),        .sine(cos_h));
  puqe_sine u_sin_s (.clk(clk), .angle(in_spin_angle), .sine(sin_s));
  puqe_sine u_cos_s (.clk(clk), .angle(spin_c),        .sine(cos_s));

  // Side data delay line, aligned with the sine outputs
  logic [11:0]        slot_d [SIN_LAT];
  logic signed [31:0] px_d   [SIN_LAT];
  logic signed [31:0] py_d   [SIN_LAT];
  logic signed [31:0] spd_d  [SIN_LAT];
  logic [30:0]        rad_d  [SIN_LAT];
  logic               last_d [SIN_LAT];
  always_ff @(posedge clk) begin
    slot_d[0] <= in_slot;
    px_d[0]   <= in_pos_x;
    py_d[0]   <= in_pos_y;
    spd_d[0]  <= in_speed;
    rad_d[0]  <= in_radius;
    last_d[0] <= in_batch_end;
    for (int i = 1; i < SIN_LAT; i++) begin
      slot_d[i] <= slot_d[i-1];
      px_d[i]   <= px_d[i-1];
      py_d[i]   <= py_d[i-1];
      spd_d[i]  <= spd_d[i-1];
      rad_d[i]  <= rad_d[i-1];
      last_d[i] <= last_d[i-1];
    end
  end

  // Stage A: trig times speed and radius
  logic signed [49:0] pvx_r, pvy_r, pxr_r, pyr_r;
  // Stage B: rounded velocity and offsets
  logic signed [32:0] vx_r, vy_r, ox_r, oy_r;
  // Stage C: velocity times time step
  logic signed [49:0] pdx_r, pdy_r;
  // Stage D: rounded deltas
  logic signed [32:0] dx_r, dy_r;
  // Stage E: new position
  logic signed [31:0] nx_r, ny_r;
  // Offsets carried along stages B..E, pass-through fields along A..F
  logic signed [32:0] oxc_r [3];
  logic signed [32:0] oyc_r [3];
  logic [11:0]        slot_p [6];
  logic               last_p [6];
  logic signed [31:0] px_p [4];
  logic signed [31:0] py_p [4];

  logic signed [34:0] vx_w, vy_w, ox_w, oy_w, dx_w, dy_w;
  logic signed [16:0] dt_s;
  assign vx_w = rnd16({pvx_r[49], pvx_r});
  assign vy_w = rnd16({pvy_r[49], pvy_r});
  assign ox_w = rnd16({pxr_r[49], pxr_r});
  assign oy_w = rnd16({pyr_r[49], pyr_r});
  assign dx_w = rnd16({pdx_r[49], pdx_r});
  assign dy_w = rnd16({pdy_r[49], pdy_r});
  assign dt_s = $signed({1'b0, dt_r});

  logic signed [31:0] rad_s;
  assign rad_s = $signed({1'b0, rad_d[SIN_LAT-1]});

  always_ff @(posedge clk) begin
    // A
    pvx_r <= sin_h * spd_d[SIN_LAT-1];
    pvy_r <= cos_h * spd_d[SIN_LAT-1];
    pxr_r <= sin_s * rad_s;
    pyr_r <= cos_s * rad_s;
    // B
    vx_r <= vx_w[32:0];
    vy_r <= vy_w[32:0];
    ox_r <= ox_w[32:0];
    oy_r <= oy_w[32:0];
    // C
    pdx_r <= vx_r * dt_s;
    pdy_r <= vy_r * dt_s;
    // D
    dx_r <= dx_w[32:0];
    dy_r <= dy_w[32:0];
    // E
    nx_r <= sat32(36'(px_p[3]) + 36'(dx_r));
    ny_r <= sat32(36'(py_p[3]) + 36'(dy_r));
    // carry offsets: C, D, E
    oxc_r[0] <= ox_r;
    oyc_r[0] <= oy_r;
    for (int i = 1; i < 3; i++) begin
      oxc_r[i] <= oxc_r[i-1];
      oyc_r[i] <= oyc_r[i-1];
    end
    // carry pass-through: A..F, positions A..D
    slot_p[0] <= slot_d[SIN_LAT-1];
    last_p[0] <= last_d[SIN_LAT-1];
    px_p[0]   <= px_d[SIN_LAT-1];
    py_p[0]   <= py_d[SIN_LAT-1];
    for (int i = 1; i < 6; i++) begin
      slot_p[i] <= slot_p[i-1];
      last_p[i] <= last_p[i-1];
    end
    for (int i = 1; i < 4; i++) begin
      px_p[i] <= px_p[i-1];
      py_p[i] <= py_p[i-1];
    end
  end

  // Stage F: corners, each saturated once
  logic signed [35:0] nx_e, ny_e, ox_e, oy_e;
  assign nx_e = 36'(nx_r);
  assign ny_e = 36'(ny_r);
  assign ox_e = 36'(oxc_r[2]);
  assign oy_e = 36'(oyc_r[2]);

  logic signed [31:0] nx_o_r, ny_o_r;
  logic signed [31:0] c0x_r, c0y_r, c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;
  always_ff @(posedge clk) begin
    nx_o_r <= nx_r;
    ny_o_r <= ny_r;
    c0x_r  <= sat32(nx_e + ox_e);
    c0y_r  <= sat32(-(ny_e + oy_e));
    c1x_r  <= sat32(nx_e + oy_e);
    c1y_r  <= sat32(-(ny_e - ox_e));
    c2x_r  <= sat32(nx_e - ox_e);
    c2y_r  <= sat32(-(ny_e - oy_e));
    c3x_r  <= sat32(nx_e - oy_e);
    c3y_r  <= sat32(-(ny_e + ox_e));
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_slot  = slot_p[5];
  assign out_last  = last_p[5];
  assign out_new_x = nx_o_r;
  assign out_new_y = ny_o_r;
  assign out_c0_x  = c0x_r;
  assign out_c0_y  = c0y_r;
  assign out_c1_x  = c1x_r;
  assign out_c1_y  = c1y_r;
  assign out_c2_x  = c2x_r;
  assign out_c2_y  = c2y_r;
  assign out_c3_x  = c3x_r;
  assign out_c3_y  = c3y_r;

  // Every transfer produces exactly one result after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##13 out_valid)
    else $error("result strobe missing after transfer");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 13))
    else $error("result strobe without transfer");

endmodule

// ----- rtl/puqe_sine.sv -----
// Pipelined fixed-point sine of a 16-bit turn fraction, signed Q2.16 result.
module puqe_sine import puqe_pkg::*; (
  input  logic        clk,
  input  logic [15:0] angle,
  output sine_t       sine
);

  logic [14:0] u_r   [6];
  logic        neg_r [6];
  logic [14:0] z2_r  [4];
  logic [30:0] h_r   [4];
  sine_t       sine_r;

  logic [30:0] coef [4];
  assign coef[0] = SIN_C7;
  assign coef[1] = SIN_C5;
  assign coef[2] = SIN_C3;
  assign coef[3] = SIN_C1;

  // Quadrant fold
  logic [14:0] u_nxt;
  assign u_nxt = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};

  // z2 = u*u >> 14
  logic [29:0] usq;
  assign usq = u_r[0] * u_r[0];

  // Horner steps, one per stage
  logic [30:0] h_nxt [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [45:0] prod;
      prod = z2_r[k] * ((k == 0) ? SIN_C9 : h_r[k-1]);
      h_nxt[k] = coef[k] - prod[44:14];
    end
  end

  // Final scale, round, clamp and sign
  logic [45:0] fin;
  logic [17:0] mag;
  assign fin = u_r[5] * h_r[3] + 46'd134217728;
  assign mag = (fin[45:28] > 18'd65536) ? 18'd65536 : fin[45:28];

  always_ff @(posedge clk) begin
    u_r[0]   <= u_nxt;
    neg_r[0] <= angle[15];
    for (int i = 1; i < 6; i++) begin
      u_r[i]   <= u_r[i-1];
      neg_r[i] <= neg_r[i-1];
    end
    z2_r[0] <= usq[28:14];
    for (int i = 1; i < 4; i++) begin
      z2_r[i] <= z2_r[i-1];
    end
    for (int k = 0; k < 4; k++) begin
      h_r[k] <= h_nxt[k];
    end
    sine_r <= neg_r[5] ? -$signed(mag) : $signed(mag);
  end

  assign sine = sine_r;

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the particle update and quad expand pipeline.
`timescale 1ns / 1ps

module tb_top import puqe_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [11:0]        slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic [15:0]        spin;
    logic signed [31:0] speed;
    logic [30:0]        radius;
    logic               batch_end;
  } particle_t;

  typedef struct {
    logic [11:0]        slot;
    logic signed [31:0] f [10];
    logic               last;
  } quad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] in_slot = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic [15:0] in_heading = '0;
  logic [15:0] in_spin_angle = '0;
  logic signed [31:0] in_speed = '0;
  logic [30:0] in_radius = '0;
  logic in_batch_end = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid;
  logic [11:0] out_slot;
  logic signed [31:0] out_new_x, out_new_y;
  logic signed [31:0] out_c0_x, out_c0_y, out_c1_x, out_c1_y;
  logic signed [31:0] out_c2_x, out_c2_y, out_c3_x, out_c3_y;
  logic out_last;

  particle_t pending_particles[$];
  quad_t     expected_quads[$];
  logic [15:0] cur_time_step = '0;
  int  gap_left = 0;
  bit  quiet = 0;
  int  error_count = 0;
  int  idle_cycles = 0;

  particle_update_quad_expand_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_slot(in_slot), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_heading(in_heading), .in_spin_angle(in_spin_angle), .in_speed(in_speed),
    .in_radius(in_radius), .in_batch_end(in_batch_end),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_slot(out_slot),
    .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_c0_x(out_c0_x), .out_c0_y(out_c0_y), .out_c1_x(out_c1_x), .out_c1_y(out_c1_y),
    .out_c2_x(out_c2_x), .out_c2_y(out_c2_y), .out_c3_x(out_c3_x), .out_c3_y(out_c3_y),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Fixed-point sine of a 16-bit turn fraction, signed Q2.16
  function automatic longint turn_sine(input logic [15:0] ang);
    longint unsigned u, z2, r, s;
    u = ang[14] ? (64'd16384 - ang[13:0]) : ang[13:0];
    z2 = (u * u) >> 14;
    r = SIN_C9;
    r = SIN_C7 - ((z2 * r) >> 14);
    r = SIN_C5 - ((z2 * r) >> 14);
    r = SIN_C3 - ((z2 * r) >> 14);
    r = SIN_C1 - ((z2 * r) >> 14);
    s = (u * r + (64'd1 << 27)) >> 28;
    if (s > 65536) s = 65536;
    return ang[15] ? -longint'(s) : longint'(s);
  endfunction

  // Drop 16 fraction bits, nearest with ties away from zero
  function automatic longint round_q16(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 32768) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Euler step and quad corners for the particle now on the input ports
  function automatic quad_t advance_particle(input logic [15:0] dt);
    quad_t q;
    longint vx, vy, nx, ny, x, y;
    vx = round_q16(turn_sine(in_heading) * longint'(in_speed));
    vy = round_q16(turn_sine(in_heading + 16'd16384) * longint'(in_speed));
    nx = clamp32(longint'(in_pos_x) + round_q16(vx * longint'(dt)));
    ny = clamp32(longint'(in_pos_y) + round_q16(vy * longint'(dt)));
    x = round_q16(turn_sine(in_spin_angle) * longint'({33'd0, in_radius}));
    y = round_q16(turn_sine(in_spin_angle + 16'd16384) * longint'({33'd0, in_radius}));
    q.slot = in_slot;
    q.f[0] = nx[31:0];
    q.f[1] = ny[31:0];
    q.f[2] = clamp32(nx + x);
    q.f[3] = clamp32(-(ny + y));
    q.f[4] = clamp32(nx + y);
    q.f[5] = clamp32(-(ny - x));
    q.f[6] = clamp32(nx - x);
    q.f[7] = clamp32(-(ny - y));
    q.f[8] = clamp32(nx - y);
    q.f[9] = clamp32(-(ny + x));
    q.last = in_batch_end;
    return q;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: one transfer per edge when start is high and busy is low
  always @(posedge clk) begin
    particle_t p;
    if (rst_n) begin
      if (start && !busy) begin
        expected_quads.push_back(advance_particle(cur_time_step));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_particles.size() > 0) begin
          p = pending_particles.pop_front();
          in_slot <= p.slot;
          in_pos_x <= p.pos_x;
          in_pos_y <= p.pos_y;
          in_heading <= p.heading;
          in_spin_angle <= p.spin;
          in_speed <= p.speed;
          in_radius <= p.radius;
          in_batch_end <= p.batch_end;
          start <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 15);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each strobed result against the oldest expectation
  always @(posedge clk) begin
    quad_t e;
    logic signed [31:0] got [10];
    if (rst_n && out_valid) begin
      if (expected_quads.size() == 0) begin
        report_mismatch("unexpected result, slot", out_slot, -1);
      end else begin
        e = expected_quads.pop_front();
        got = '{out_new_x, out_new_y, out_c0_x, out_c0_y, out_c1_x, out_c1_y,
                out_c2_x, out_c2_y, out_c3_x, out_c3_y};
        if (out_slot !== e.slot) report_mismatch("slot", out_slot, e.slot);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        for (int i = 0; i < 10; i++) begin
          if (got[i] !== e.f[i]) report_mismatch($sformatf("field %0d", i), got[i], e.f[i]);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_particle(input logic [11:0] slot, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic [15:0] hd,
                              input logic [15:0] sp, input logic signed [31:0] spd,
                              input logic [30:0] rad, input logic last);
    particle_t p;
    p = '{slot, px, py, hd, sp, spd, rad, last};
    pending_particles.push_back(p);
  endtask

  task automatic add_random_particle();
    logic signed [31:0] px, py, spd;
    logic [30:0] rad;
    if ($urandom_range(0, 3) == 0) begin
      px = $urandom(); py = $urandom(); spd = $urandom(); rad = 31'($urandom());
    end else begin
      px = $signed($urandom_range(0, 2097151)) - 1048576;
      py = $signed($urandom_range(0, 2097151)) - 1048576;
      spd = $signed($urandom_range(0, 16777215)) - 8388608;
      rad = 31'($urandom_range(0, 1048575));
    end
    add_particle(12'($urandom()), px, py, 16'($urandom()), 16'($urandom()), spd, rad,
                 $urandom_range(0, 7) == 0);
  endtask

  // Wait until nothing is in flight, then write the time step
  task automatic set_time_step(input logic [15:0] dt);
    while (pending_particles.size() > 0 || expected_quads.size() > 0 || start)
      @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_time_step = dt;
  endtask

  initial begin
    logic [15:0] steps [5];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, quadrant boundaries, saturation
    set_time_step(16'hFFFF);
    add_particle(12'd0, 32'sd0, 32'sd0, 16'd0, 16'd0, 32'sd0, 31'd0, 1'b0);
    add_particle(12'hFFF, 32'sd0, 32'sd0, 16'd16384, 16'd16384, 32'sd65536, 31'd65536, 1'b1);
    add_particle(12'd1, 32'sd100, -32'sd100, 16'd32768, 16'd32768, 32'sd65536, 31'd65536, 1'b0);
    add_particle(12'd2, 32'sd0, 32'sd0, 16'd49152, 16'd49152, -32'sd65536, 31'd1, 1'b0);
    add_particle(12'd3, 32'sd0, 32'sd0, 16'hFFFF, 16'hFFFF, 32'sd12345, 31'd12345, 1'b0);
    add_particle(12'd4, 32'sd0, 32'sd0, 16'd8192, 16'd24576, 32'sd7, 31'd3, 1'b0);
    add_particle(12'd5, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd8192, 16'd8192,
                 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b0);
    add_particle(12'd6, 32'sh80000000, 32'sh80000000, 16'd40960, 16'd40960,
                 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b1);
    add_particle(12'd7, 32'sh80000000, 32'sh7FFFFFFF, 16'd0, 16'd0,
                 32'sh80000000, 31'h7FFFFFFF, 1'b0);
    add_particle(12'd8, 32'sh7FFFFFFF, 32'sh80000000, 16'd16384, 16'd32768,
                 32'sh80000000, 31'h7FFFFFFF, 1'b0);
    add_particle(12'd9, 32'sd0, 32'sh7FFFFFFF, 16'd1, 16'd16383, 32'sh7FFFFFFF, 31'd0, 1'b0);
    add_particle(12'd10, -32'sd1, -32'sd1, 16'd16385, 16'd49151, -32'sd1, 31'd1, 1'b1);
    repeat (8) add_random_particle();
    set_time_step(16'd0);
    add_particle(12'd11, 32'sd5, 32'sd5, 16'd8192, 16'd8192, 32'sh7FFFFFFF, 31'd65536, 1'b1);
    add_particle(12'd12, 32'sh7FFFFFFF, 32'sh80000000, 16'd0, 16'd0, 32'sd0, 31'h7FFFFFFF, 1'b0);

    // Random phases across time steps, last one without gaps
    steps = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(0, 2000)), 16'($urandom())};
    for (int ph = 0; ph < 5; ph++) begin
      set_time_step(steps[ph]);
      if (ph == 4) quiet = 1;
      repeat (186) add_random_particle();
    end

    while (pending_particles.size() > 0 || expected_quads.size() > 0 || start)
      @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
